FILE: rtl/hump_pkg.sv
package hump_pkg;

  localparam int POINT_CAPACITY_DEF = 128;
  localparam int SPAN_CAPACITY_DEF  = 32;
  localparam int VEHICLE_X_DEF      = 233;
  localparam int VEHICLE_Y_DEF      = 254;

  localparam logic [45:0] AXIS_CAP    = '1;
  localparam int          PIXEL_LIMIT = 2000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POINT,
    ST_SPAN,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_LAT,
    REG_ORIGIN_LON,
    REG_EAST_SCALE,
    REG_NORTH_SCALE,
    REG_HEADING_SIN,
    REG_HEADING_COS,
    REG_LAYER_COUNT,
    REG_MIN_SPAN
  } reg_index_t;

  // one multiplier issue (or bookkeeping step) per cycle of a point
  typedef enum logic [3:0] {
    SP_MAG,
    SP_LON_HI,
    SP_LON_LO,
    SP_LAT_HI,
    SP_LAT_LO,
    SP_EAST_COS,
    SP_NORTH_SIN,
    SP_EAST_SIN,
    SP_NORTH_COS,
    SP_Y_LAST,
    SP_ROUND_Y
  } step_t;

  // Q31 to whole pixels, half away from zero, clamped
  function automatic logic [11:0] to_pixel(input logic signed [64:0] v);
    logic signed [64:0] t;
    logic signed [33:0] r;
    t = v + (v[64] ? 65'sd1073741823 : 65'sd1073741824);
    r = t[64:31];
    if (r > 34'(PIXEL_LIMIT)) begin
      return 12'(PIXEL_LIMIT);
    end else if (r < -34'(PIXEL_LIMIT)) begin
      return 12'(-PIXEL_LIMIT);
    end else begin
      return r[11:0];
    end
  endfunction

endpackage

FILE: rtl/heading_up_map_point_projector_top.sv
// Heading-up map point projector.
// Input channel (in_valid/in_stall) takes one item per beat: a map point
// (func 0) or a span descriptor (func 1); frame_start clears the point,
// span and accepted counters before the item. Output channel
// (out_valid/out_stall) gives at most one result beat per item.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// eight setup registers; it is ready except in reset. The user must see that it
// is written while idle; the block itself does not enforce it. A point runs
// through one shared 48x17 signed multiplier under a step sequencer: 8
// products plus magnitude, final accumulate and rounding steps, then the
// ST_OUT state loads the output register, and the next item is taken once
// that load is done. A span goes through ST_SPAN and then ST_OUT; a rejected
// span frees the input after ST_SPAN, a point over capacity at once.
// Items are taken one at a time: in_stall is high in reset and while an item
// is in work. A finished result sits in the output register while the next
// item is accepted; if the receiver still stalls when the next result is
// done, the sequencer holds until the output register frees.
// Dropped items (over capacity, rejected spans) give no beat.
// Reset clears counters, the sequencer and the output valid and loads the
// register defaults (cosine 32767, minimum span points 2).
module heading_up_map_point_projector_top
  import hump_pkg::*;
#(
  parameter int POINT_CAPACITY = POINT_CAPACITY_DEF,
  parameter int SPAN_CAPACITY  = SPAN_CAPACITY_DEF,
  parameter int VEHICLE_X      = VEHICLE_X_DEF,
  parameter int VEHICLE_Y      = VEHICLE_Y_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic               frame_start,
  input  logic signed [30:0] latitude_e7,
  input  logic signed [31:0] longitude_e7,
  input  logic [7:0]         span_start_index,
  input  logic [7:0]         span_length,
  input  logic [7:0]         span_class,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic signed [11:0] x_pixel,
  output logic signed [11:0] y_pixel,
  output logic [7:0]         slot_index,
  output logic [7:0]         kept_start_index,
  output logic [7:0]         kept_length,
  output logic [7:0]         kept_class
);

  // setup registers
  logic signed [30:0] origin_lat;
  logic signed [31:0] origin_lon;
  logic [31:0]        east_scale;
  logic [31:0]        north_scale;
  logic signed [15:0] heading_sin;
  logic signed [15:0] heading_cos;
  logic [7:0]         layer_point_count;
  logic [7:0]         min_span_points;

  state_t state, state_next;
  step_t  step;

  logic [7:0] point_counter;
  logic [5:0] spans_seen;
  logic [5:0] spans_accepted;

  // item in work
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic [31:0]        lat_mag;
  logic [31:0]        lon_mag;
  logic               lat_neg;
  logic               lon_neg;
  logic signed [46:0] east;
  logic signed [46:0] north;
  logic [7:0]         sp_start;
  logic [7:0]         sp_len;
  logic [7:0]         sp_class;

  // shared multiplier and accumulator
  logic signed [47:0] opa;
  logic signed [16:0] opb;
  logic signed [64:0] prod;
  logic signed [64:0] acc;

  // staged result
  logic               res_kind;
  logic [11:0]        res_x;
  logic [11:0]        res_y;
  logic [7:0]         res_slot;
  logic [7:0]         res_start;
  logic [7:0]         res_len;
  logic [7:0]         res_class;

  logic       in_fire;
  logic       load_out;
  logic [7:0] pc_base;
  logic [5:0] seen_base;
  logic [5:0] accepted_base;
  logic       point_ok;
  logic       span_ok;
  logic [7:0] layer;
  logic       keep;
  logic [48:0] axis_sum;
  logic [45:0] axis_cap;
  logic signed [46:0] axis_val;

  localparam logic signed [64:0] VX_Q31 = 65'(VEHICLE_X) << 31;
  localparam logic signed [64:0] VY_Q31 = 65'(VEHICLE_Y) << 31;

  assign cfg_ready = !rst;
  assign in_fire   = in_valid && !in_stall;

  assign pc_base       = frame_start ? '0 : point_counter;
  assign seen_base     = frame_start ? '0 : spans_seen;
  assign accepted_base = frame_start ? '0 : spans_accepted;
  assign point_ok      = pc_base < 8'(POINT_CAPACITY);
  assign span_ok       = seen_base < 6'(SPAN_CAPACITY);

  assign layer = (layer_point_count > 8'(POINT_CAPACITY)) ? 8'(POINT_CAPACITY)
                                                          : layer_point_count;
  assign keep  = (sp_len >= min_span_points) && (sp_start < layer) &&
                 (sp_len <= 8'(layer - sp_start));

  // hi product in acc plus lo product shifted down, then cap and sign
  assign axis_sum = acc[48:0] + {17'b0, prod[47:16]};
  assign axis_cap = (axis_sum > {3'b0, AXIS_CAP}) ? AXIS_CAP : axis_sum[45:0];

  always_comb begin
    axis_val = {1'b0, axis_cap};
    if ((step == SP_LAT_HI) ? lon_neg : lat_neg) begin
      axis_val = -{1'b0, axis_cap};
    end
  end

  always_comb begin
    case (step)
      SP_LON_HI: begin
        opa = {16'b0, lon_mag};
        opb = {1'b0, east_scale[31:16]};
      end
      SP_LON_LO: begin
        opa = {16'b0, lon_mag};
        opb = {1'b0, east_scale[15:0]};
      end
      SP_LAT_HI: begin
        opa = {16'b0, lat_mag};
        opb = {1'b0, north_scale[31:16]};
      end
      SP_LAT_LO: begin
        opa = {16'b0, lat_mag};
        opb = {1'b0, north_scale[15:0]};
      end
      SP_EAST_COS: begin
        opa = 48'(east);
        opb = 17'(heading_cos);
      end
      SP_NORTH_SIN: begin
        opa = 48'(north);
        opb = 17'(heading_sin);
      end
      SP_EAST_SIN: begin
        opa = 48'(east);
        opb = 17'(heading_sin);
      end
      SP_NORTH_COS: begin
        opa = 48'(north);
        opb = 17'(heading_cos);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (!func && point_ok) begin
            state_next = ST_POINT;
          end else if (func && span_ok) begin
            state_next = ST_SPAN;
          end
        end
      end
      ST_POINT: begin
        if (step == SP_ROUND_Y) begin
          state_next = ST_OUT;
        end
      end
      ST_SPAN: begin
        state_next = keep ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        load_out = !out_valid || !out_stall;
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = rst || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // setup registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_lat        <= '0;
      origin_lon        <= '0;
      east_scale        <= '0;
      north_scale       <= '0;
      heading_sin       <= '0;
      heading_cos       <= 16'sd32767;
      layer_point_count <= '0;
      min_span_points   <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_ORIGIN_LAT:  origin_lat        <= cfg_data[30:0];
        REG_ORIGIN_LON:  origin_lon        <= cfg_data;
        REG_EAST_SCALE:  east_scale        <= cfg_data;
        REG_NORTH_SCALE: north_scale       <= cfg_data;
        REG_HEADING_SIN: heading_sin       <= cfg_data[15:0];
        REG_HEADING_COS: heading_cos       <= cfg_data[15:0];
        REG_LAYER_COUNT: layer_point_count <= cfg_data[7:0];
        REG_MIN_SPAN:    min_span_points   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      point_counter  <= '0;
      spans_seen     <= '0;
      spans_accepted <= '0;
    end else if (in_fire) begin
      point_counter  <= (!func && point_ok) ? pc_base + 8'd1 : pc_base;
      spans_seen     <= (func && span_ok) ? seen_base + 6'd1 : seen_base;
      spans_accepted <= accepted_base;
    end else if (state == ST_SPAN && keep) begin
      spans_accepted <= spans_accepted + 6'd1;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= SP_MAG;
    end else if (in_fire) begin
      step <= SP_MAG;
    end else if (state == ST_POINT && step != SP_ROUND_Y) begin
      step <= step_t'(step + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    if (in_fire) begin
      dlat     <= 32'(latitude_e7) - 32'(origin_lat);
      dlon     <= 33'(longitude_e7) - 33'(origin_lon);
      sp_start <= span_start_index;
      sp_len   <= span_length;
      sp_class <= span_class;
      res_slot <= pc_base;
    end
    if (state == ST_POINT) begin
      case (step)
        SP_MAG: begin
          lat_neg <= dlat[31];
          lon_neg <= dlon[32];
          lat_mag <= dlat[31] ? 32'(-dlat) : 32'(dlat);
          lon_mag <= dlon[32] ? 32'(-dlon) : 32'(dlon);
        end
        SP_LON_LO:    acc   <= prod;
        SP_LAT_HI:    east  <= axis_val;
        SP_LAT_LO:    acc   <= prod;
        SP_EAST_COS:  north <= axis_val;
        SP_NORTH_SIN: acc   <= VX_Q31 + prod;
        SP_EAST_SIN:  acc   <= acc - prod;
        SP_NORTH_COS: begin
          res_x <= to_pixel(acc);
          acc   <= VY_Q31 - prod;
        end
        SP_Y_LAST:    acc   <= acc - prod;
        SP_ROUND_Y: begin
          res_y     <= to_pixel(acc);
          res_kind  <= 1'b0;
          res_start <= '0;
          res_len   <= '0;
          res_class <= '0;
        end
        default: begin
        end
      endcase
    end
    if (state == ST_SPAN) begin
      res_kind  <= 1'b1;
      res_x     <= '0;
      res_y     <= '0;
      res_slot  <= {2'b0, spans_accepted};
      res_start <= sp_start;
      res_len   <= sp_len;
      res_class <= sp_class;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind             <= res_kind;
      x_pixel          <= res_x;
      y_pixel          <= res_y;
      slot_index       <= res_slot;
      kept_start_index <= res_start;
      kept_length      <= res_len;
      kept_class       <= res_class;
    end
  end

  a_point_counter_bound: assert property (@(posedge clk) disable iff (rst)
    point_counter <= 8'(POINT_CAPACITY))
    else $error("point counter past capacity");

  a_accepted_le_seen: assert property (@(posedge clk) disable iff (rst)
    spans_accepted <= spans_seen)
    else $error("more spans accepted than seen");

  a_span_beat_no_xy: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> x_pixel == 12'sd0 && y_pixel == 12'sd0)
    else $error("span beat carries pixel coordinates");

  a_point_beat_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> x_pixel >= -12'sd2000 && x_pixel <= 12'sd2000 &&
                          y_pixel >= -12'sd2000 && y_pixel <= 12'sd2000)
    else $error("point beat outside clamp range");

  a_busy_no_out_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> in_stall == 1'b0)
    else $error("sequencer stayed busy after loading output");

endmodule

FILE: bench/tb_heading_up_map_point_projector_top.sv
`timescale 1ns / 1ps

module tb_heading_up_map_point_projector_top
  import hump_pkg::*;
();

  localparam logic   FUNC_POINT    = 1'b0;
  localparam logic   FUNC_SPAN     = 1'b1;
  localparam logic   KIND_POINT    = 1'b0;
  localparam logic   KIND_SPAN     = 1'b1;
  localparam int     SETTLE_CYCLES = 24;
  localparam int     CYCLE_LIMIT   = 500000;
  localparam longint LAT_MAX       = 900000000;
  localparam longint LON_MAX       = 1800000000;

  typedef struct packed {
    logic        func;
    logic        frame_start;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [7:0]  start;
    logic [7:0]  len;
    logic [7:0]  cls;
  } map_item_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  slot;
    logic [7:0]  kstart;
    logic [7:0]  klen;
    logic [7:0]  kclass;
  } map_beat_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               func;
  logic               frame_start;
  logic signed [30:0] latitude_e7;
  logic signed [31:0] longitude_e7;
  logic [7:0]         span_start_index;
  logic [7:0]         span_length;
  logic [7:0]         span_class;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic signed [11:0] x_pixel;
  logic signed [11:0] y_pixel;
  logic [7:0]         slot_index;
  logic [7:0]         kept_start_index;
  logic [7:0]         kept_length;
  logic [7:0]         kept_class;

  // shadow copy of the setup registers and the frame counters
  logic [30:0] org_lat;
  logic [31:0] org_lon;
  logic [31:0] e_scale;
  logic [31:0] n_scale;
  logic [15:0] h_sin;
  logic [15:0] h_cos;
  logic [7:0]  layer_cnt;
  logic [7:0]  min_pts;
  int          pt_count;
  int          span_seen;
  int          span_kept;

  map_beat_t predicted_q[$];
  map_beat_t want_beat;
  int        tx_idle_pct;
  int        rx_stall_pct;
  int        fail_count;
  int        items_sent;
  int        point_beats;
  int        span_beats;
  int        view_count;
  int        cycle_count;

  heading_up_map_point_projector_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (func),
    .frame_start      (frame_start),
    .latitude_e7      (latitude_e7),
    .longitude_e7     (longitude_e7),
    .span_start_index (span_start_index),
    .span_length      (span_length),
    .span_class       (span_class),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .x_pixel          (x_pixel),
    .y_pixel          (y_pixel),
    .slot_index       (slot_index),
    .kept_start_index (kept_start_index),
    .kept_length      (kept_length),
    .kept_class       (kept_class)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Q16 pixels on one axis, magnitude saturated
  function automatic longint scale_axis(input longint d, input logic [31:0] scale);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    q = (mag * {32'd0, scale}) >> 16;
    if (q > 64'(AXIS_CAP)) q = 64'(AXIS_CAP);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [11:0] q31_to_pixel(input longint v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    r = (mag + 64'h4000_0000) >> 31;
    if (r > 64'(PIXEL_LIMIT)) r = 64'(PIXEL_LIMIT);
    if (v < 0) r = -r;
    return r[11:0];
  endfunction

  function automatic void project_item(input map_item_t it);
    longint    dlat;
    longint    dlon;
    longint    east;
    longint    north;
    longint    s;
    longint    c;
    longint    xq;
    longint    yq;
    int        layer;
    int        st;
    int        ln;
    map_beat_t r;
    if (it.frame_start) begin
      pt_count  = 0;
      span_seen = 0;
      span_kept = 0;
    end
    r = '0;
    if (it.func == FUNC_POINT) begin
      if (pt_count >= POINT_CAPACITY_DEF) return;
      dlat  = longint'($signed(it.lat)) - longint'($signed(org_lat));
      dlon  = longint'($signed(it.lon)) - longint'($signed(org_lon));
      east  = scale_axis(dlon, e_scale);
      north = scale_axis(dlat, n_scale);
      s     = longint'($signed(h_sin));
      c     = longint'($signed(h_cos));
      // rotate heading-up, screen y grows downward
      xq = (longint'(VEHICLE_X_DEF) <<< 31) + (east * c - north * s);
      yq = (longint'(VEHICLE_Y_DEF) <<< 31) - (east * s + north * c);
      r.kind = KIND_POINT;
      r.x    = q31_to_pixel(xq);
      r.y    = q31_to_pixel(yq);
      r.slot = 8'(pt_count);
      pt_count++;
      predicted_q.push_back(r);
    end else begin
      if (span_seen >= SPAN_CAPACITY_DEF) return;
      span_seen++;
      layer = (layer_cnt > POINT_CAPACITY_DEF) ? POINT_CAPACITY_DEF : int'(layer_cnt);
      st    = it.start;
      ln    = it.len;
      if (ln < int'(min_pts) || st >= layer || ln > layer - st) return;
      r.kind   = KIND_SPAN;
      r.slot   = 8'(span_kept);
      r.kstart = it.start;
      r.klen   = it.len;
      r.kclass = it.cls;
      span_kept++;
      predicted_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (predicted_q.size() == 0) begin
        $error("result beat with nothing pending: kind %0d slot %0d", kind, slot_index);
        fail_count++;
      end else begin
        want_beat = predicted_q.pop_front();
        if (want_beat.kind == KIND_POINT) point_beats++;
        else span_beats++;
        check_field("kind", want_beat.kind, kind);
        check_field("x_pixel", $signed(want_beat.x), x_pixel);
        check_field("y_pixel", $signed(want_beat.y), y_pixel);
        check_field("slot_index", want_beat.slot, slot_index);
        check_field("kept_start_index", want_beat.kstart, kept_start_index);
        check_field("kept_length", want_beat.klen, kept_length);
        check_field("kept_class", want_beat.kclass, kept_class);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic set_idle(input int tx, input int rx);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  // stop sending and let every pending beat and any dropped item finish
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_ORIGIN_LAT:  org_lat   = data[30:0];
      REG_ORIGIN_LON:  org_lon   = data;
      REG_EAST_SCALE:  e_scale   = data;
      REG_NORTH_SCALE: n_scale   = data;
      REG_HEADING_SIN: h_sin     = data[15:0];
      REG_HEADING_COS: h_cos     = data[15:0];
      REG_LAYER_COUNT: layer_cnt = data[7:0];
      REG_MIN_SPAN:    min_pts   = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_view(input longint olat, input longint olon, input logic [31:0] es,
                          input logic [31:0] ns, input logic [15:0] sn,
                          input logic [15:0] cs);
    drain_results();
    cfg_write(REG_ORIGIN_LAT, 32'(olat));
    cfg_write(REG_ORIGIN_LON, 32'(olon));
    cfg_write(REG_EAST_SCALE, es);
    cfg_write(REG_NORTH_SCALE, ns);
    cfg_write(REG_HEADING_SIN, {16'd0, sn});
    cfg_write(REG_HEADING_COS, {16'd0, cs});
    view_count++;
  endtask

  task automatic set_span_rules(input logic [7:0] layer, input logic [7:0] minp);
    drain_results();
    cfg_write(REG_LAYER_COUNT, {24'd0, layer});
    cfg_write(REG_MIN_SPAN, {24'd0, minp});
  endtask

  task automatic send_item(input map_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct && gap < 40) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    func             <= it.func;
    frame_start      <= it.frame_start;
    latitude_e7      <= it.lat;
    longitude_e7     <= it.lon;
    span_start_index <= it.start;
    span_length      <= it.len;
    span_class       <= it.cls;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    project_item(it);
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic map_item_t make_point(input bit fs, input longint lat,
                                           input longint lon);
    map_item_t it;
    it.func        = FUNC_POINT;
    it.frame_start = fs;
    it.lat         = 31'(lat);
    it.lon         = 32'(lon);
    it.start       = 8'($urandom);
    it.len         = 8'($urandom);
    it.cls         = 8'($urandom);
    return it;
  endfunction

  function automatic map_item_t make_span(input bit fs, input logic [7:0] st,
                                          input logic [7:0] ln, input logic [7:0] cl);
    map_item_t it;
    it.func        = FUNC_SPAN;
    it.frame_start = fs;
    it.lat         = 31'(longint'($urandom_range(0, 1800000000)) - LAT_MAX);
    it.lon         = 32'(longint'($urandom_range(0, 32'd3600000000)) - LON_MAX);
    it.start       = st;
    it.len         = ln;
    it.cls         = cl;
    return it;
  endfunction

  // mostly points near the view origin so results land on screen
  function automatic map_item_t rand_point(input bit fs);
    longint lat;
    longint lon;
    if ($urandom_range(0, 3) != 0) begin
      lat = longint'($signed(org_lat)) + longint'($urandom_range(0, 262144)) - 131072;
      lon = longint'($signed(org_lon)) + longint'($urandom_range(0, 262144)) - 131072;
    end else begin
      lat = longint'($urandom_range(0, 1800000000)) - LAT_MAX;
      lon = longint'($urandom_range(0, 32'd3600000000)) - LON_MAX;
    end
    if (lat > LAT_MAX) lat = LAT_MAX;
    if (lat < -LAT_MAX) lat = -LAT_MAX;
    if (lon > LON_MAX) lon = LON_MAX;
    if (lon < -LON_MAX) lon = -LON_MAX;
    return make_point(fs, lat, lon);
  endfunction

  function automatic map_item_t rand_span(input bit fs);
    int         lim;
    logic [7:0] st;
    logic [7:0] ln;
    lim = (layer_cnt > POINT_CAPACITY_DEF) ? POINT_CAPACITY_DEF : int'(layer_cnt);
    st  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, lim));
    ln  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    return make_span(fs, st, ln, 8'($urandom));
  endfunction

  task automatic run_frames(input int n);
    bit fs;
    for (int i = 0; i < n; i++) begin
      fs = (i == 0) || ($urandom_range(0, 99) < 3);
      if ($urandom_range(0, 99) < 75) send_item(rand_point(fs));
      else send_item(rand_span(fs));
    end
  endtask

  task automatic randomize_config();
    logic [31:0] es;
    logic [31:0] ns;
    logic [7:0]  minp;
    es = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0400_0000);
    ns = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0400_0000);
    set_view(longint'($urandom_range(0, 1800000000)) - LAT_MAX,
             longint'($urandom_range(0, 32'd3600000000)) - LON_MAX,
             es, ns, 16'($urandom), 16'($urandom));
    case ($urandom_range(0, 5))
      0, 1: minp = 8'd2;
      2, 3: minp = 8'd3;
      4: minp = 8'($urandom_range(0, 1));
      default: minp = 8'($urandom_range(4, 255));
    endcase
    set_span_rules(8'($urandom_range(0, 255)), minp);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // zero scales after reset pin every point to the vehicle; layer 0 rejects spans
  task automatic test_reset_defaults();
    set_idle(0, 0);
    send_item(make_point(1'b1, 0, 0));
    send_item(make_point(1'b0, LAT_MAX, -LON_MAX));
    send_item(make_span(1'b0, 8'd0, 8'd2, 8'h5A));
  endtask

  task automatic test_point_math();
    set_idle(0, 0);
    // unit scale, cos -1: x moves one pixel per 2^16 of longitude
    set_view(0, 0, 32'h0001_0000, 32'h0001_0000, 16'h0000, 16'h8000);
    send_item(make_point(1'b1, 0, 32768));
    send_item(make_point(1'b0, 0, 300 * 65536 + 32768));
    send_item(make_point(1'b0, LAT_MAX, LON_MAX));
    send_item(make_point(1'b0, -LAT_MAX, -LON_MAX));
    send_item(make_point(1'b0, 12345, -6789));
    // full scale from the far corner: both axes saturate at the opposite corner
    set_view(-LAT_MAX, -LON_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000);
    send_item(make_point(1'b1, LAT_MAX, LON_MAX));
    send_item(make_point(1'b0, -LAT_MAX, -LON_MAX));
    send_item(make_point(1'b0, 0, 0));
    set_view(LAT_MAX, LON_MAX, 32'hFFFF_FFFF, 32'h0000_0001, 16'h8000, 16'h7FFF);
    send_item(make_point(1'b1, -LAT_MAX, -LON_MAX));
    send_item(make_point(1'b0, LAT_MAX - 1, LON_MAX - 3));
  endtask

  task automatic test_span_filter();
    set_idle(0, 0);
    // layer above capacity caps at capacity; minimum 0 lets empty spans through
    set_span_rules(8'd255, 8'd0);
    send_item(make_span(1'b1, 8'd0, 8'd0, 8'h00));
    send_item(make_span(1'b0, 8'd127, 8'd1, 8'hFF));
    send_item(make_span(1'b0, 8'd128, 8'd0, 8'h11));
    send_item(make_span(1'b0, 8'd0, 8'd128, 8'h22));
    send_item(make_span(1'b0, 8'd1, 8'd128, 8'h33));
    send_item(make_span(1'b0, 8'd255, 8'd255, 8'hFF));
    set_span_rules(8'd10, 8'd3);
    send_item(make_span(1'b1, 8'd7, 8'd3, 8'hA5));
    send_item(make_span(1'b0, 8'd7, 8'd4, 8'h5A));
    send_item(make_point(1'b0, 0, 0));
    send_item(make_span(1'b0, 8'd0, 8'd2, 8'h01));
    send_item(make_span(1'b0, 8'd0, 8'd255, 8'h02));
    set_span_rules(8'd128, 8'd255);
    send_item(make_span(1'b1, 8'd0, 8'd255, 8'h03));
    set_span_rules(8'd128, 8'd1);
    send_item(make_span(1'b0, 8'd0, 8'd1, 8'h04));
    send_item(make_span(1'b0, 8'd5, 8'd0, 8'h05));
  endtask

  // overfill both counters in one frame, then restart the frame
  task automatic test_capacity();
    set_idle(35, 35);
    send_item(rand_point(1'b1));
    repeat (POINT_CAPACITY_DEF + 2) send_item(rand_point(1'b0));
    repeat (SPAN_CAPACITY_DEF + 2) send_item(rand_span(1'b0));
    send_item(rand_point(1'b1));
    send_item(rand_span(1'b1));
  endtask

  task automatic test_random_traffic(input int tx, input int rx, input int n);
    randomize_config();
    set_idle(tx, rx);
    run_frames(n);
  endtask

  // sender holds off until the block has delivered everything
  task automatic test_drain_pause();
    set_idle(35, 35);
    run_frames(20);
    drain_results();
    run_frames(20);
  endtask

  initial begin
    rst              = 1'b1;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    func             = FUNC_POINT;
    frame_start      = 1'b0;
    latitude_e7      = '0;
    longitude_e7     = '0;
    span_start_index = '0;
    span_length      = '0;
    span_class       = '0;
    org_lat          = '0;
    org_lon          = '0;
    e_scale          = '0;
    n_scale          = '0;
    h_sin            = '0;
    h_cos            = 16'h7FFF;
    layer_cnt        = '0;
    min_pts          = 8'd2;
    pt_count         = 0;
    span_seen        = 0;
    span_kept        = 0;
    set_idle(0, 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_point_math();
    test_span_filter();
    test_capacity();
    test_random_traffic(0, 0, 100);
    test_random_traffic(64, 0, 100);
    test_random_traffic(0, 64, 100);
    test_random_traffic(35, 35, 100);
    test_drain_pause();

    drain_results();
    $display("Checked %0d point and %0d span beats from %0d items over %0d view setups,",
             point_beats, span_beats, items_sent, view_count);
    $display("including rounding, clamping, saturation, span rules and capacity overflow.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
